// ===== rtl/core/sensor_response_frame_crc16_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Sensor response frame CRC16 unit - assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef SENSOR_RESPONSE_FRAME_CRC16_UNIT_DEFINES_SVH
`define SENSOR_RESPONSE_FRAME_CRC16_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define SRFC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");

// Next-cycle implication, checked outside reset.
`define SRFC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: ante implies cons next cycle");

`else

`define SRFC_ASSERT_NOW(label, clk, rstn, ante, cons)
`define SRFC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/srfc_pkg.sv =====
// ---------------------------------------------------------------------------
// srfc_pkg
// Shared types, frame constants and the bytewise CRC-16 step.
// ---------------------------------------------------------------------------
package srfc_pkg;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  FUNC_CODE  = 8'h04;
    localparam logic [7:0]  BYTE_COUNT = 8'h06;
    localparam logic [7:0]  PAD_BYTE   = 8'h00;

    localparam int NUM_STAGES = 4;

    // Byte positions in the frame, in send order
    localparam logic [3:0] IDX_ADDR    = 4'd0;
    localparam logic [3:0] IDX_FUNC    = 4'd1;
    localparam logic [3:0] IDX_COUNT   = 4'd2;
    localparam logic [3:0] IDX_IT_HI   = 4'd3;
    localparam logic [3:0] IDX_IT_LO   = 4'd4;
    localparam logic [3:0] IDX_ET_HI   = 4'd5;
    localparam logic [3:0] IDX_ET_LO   = 4'd6;
    localparam logic [3:0] IDX_CV_HI   = 4'd7;
    localparam logic [3:0] IDX_CV_LO   = 4'd8;
    localparam logic [3:0] IDX_PAD0    = 4'd9;
    localparam logic [3:0] IDX_PAD1    = 4'd10;
    localparam logic [3:0] IDX_CRC_HI  = 4'd11;
    localparam logic [3:0] IDX_CRC_LO  = 4'd12;

    typedef struct packed {
        logic [15:0] inner_temp;
        logic [15:0] outer_temp;
        logic [15:0] cell_voltage;
        logic [15:0] crc;
    } frame_req_t;

    // One byte through the reflected CRC-16, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/srfc_crc_pipe.sv =====
// ---------------------------------------------------------------------------
// srfc_crc_pipe
// Four-stage CRC pipeline over frame bytes 0..10: three bytes per stage, two in the last.
// ---------------------------------------------------------------------------
`include "sensor_response_frame_crc16_unit_defines.svh"

module srfc_crc_pipe (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          slave_address,
    input  logic                in_valid,
    output logic                in_ready,
    input  srfc_pkg::frame_req_t in_req,
    output logic                out_valid,
    input  logic                out_ready,
    output srfc_pkg::frame_req_t out_req
);

    logic                 stage_valid_reg [srfc_pkg::NUM_STAGES];
    srfc_pkg::frame_req_t stage_data_reg  [srfc_pkg::NUM_STAGES];
    srfc_pkg::frame_req_t stage_next      [srfc_pkg::NUM_STAGES];
    logic                 stage_ready     [srfc_pkg::NUM_STAGES + 1];
    logic                 stage_in_valid  [srfc_pkg::NUM_STAGES];

    // Backpressure: a stage takes a request when empty or when it drains
    always_comb begin
        stage_ready[srfc_pkg::NUM_STAGES] = out_ready;
        for (int k = srfc_pkg::NUM_STAGES - 1; k >= 0; k--) begin
            stage_ready[k] = !stage_valid_reg[k] || stage_ready[k + 1];
        end
        stage_in_valid[0] = in_valid;
        for (int k = 1; k < srfc_pkg::NUM_STAGES; k++) begin
            stage_in_valid[k] = stage_valid_reg[k - 1];
        end
    end

    // Stage 0: address, function code, byte count
    always_comb begin
        stage_next[0]     = in_req;
        stage_next[0].crc = srfc_pkg::crc_byte(srfc_pkg::CRC_INIT, slave_address);
        stage_next[0].crc = srfc_pkg::crc_byte(stage_next[0].crc, srfc_pkg::FUNC_CODE);
        stage_next[0].crc = srfc_pkg::crc_byte(stage_next[0].crc, srfc_pkg::BYTE_COUNT);
    end

    // Stage 1: inner reading, outer high byte
    always_comb begin
        stage_next[1]     = stage_data_reg[0];
        stage_next[1].crc = srfc_pkg::crc_byte(stage_data_reg[0].crc,
                                               stage_data_reg[0].inner_temp[15:8]);
        stage_next[1].crc = srfc_pkg::crc_byte(stage_next[1].crc,
                                               stage_data_reg[0].inner_temp[7:0]);
        stage_next[1].crc = srfc_pkg::crc_byte(stage_next[1].crc,
                                               stage_data_reg[0].outer_temp[15:8]);
    end

    // Stage 2: outer low byte, cell reading
    always_comb begin
        stage_next[2]     = stage_data_reg[1];
        stage_next[2].crc = srfc_pkg::crc_byte(stage_data_reg[1].crc,
                                               stage_data_reg[1].outer_temp[7:0]);
        stage_next[2].crc = srfc_pkg::crc_byte(stage_next[2].crc,
                                               stage_data_reg[1].cell_voltage[15:8]);
        stage_next[2].crc = srfc_pkg::crc_byte(stage_next[2].crc,
                                               stage_data_reg[1].cell_voltage[7:0]);
    end

    // Stage 3: two pad bytes
    always_comb begin
        stage_next[3]     = stage_data_reg[2];
        stage_next[3].crc = srfc_pkg::crc_byte(stage_data_reg[2].crc, srfc_pkg::PAD_BYTE);
        stage_next[3].crc = srfc_pkg::crc_byte(stage_next[3].crc, srfc_pkg::PAD_BYTE);
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < srfc_pkg::NUM_STAGES; k++) begin
            if (!aresetn) begin
                stage_valid_reg[k] <= 1'b0;
            end else if (stage_ready[k]) begin
                stage_valid_reg[k] <= stage_in_valid[k];
            end
            if (stage_ready[k] && stage_in_valid[k]) begin
                stage_data_reg[k] <= stage_next[k];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = stage_valid_reg[srfc_pkg::NUM_STAGES - 1];
    assign out_req   = stage_data_reg[srfc_pkg::NUM_STAGES - 1];

    `SRFC_ASSERT_NEXT(a_pipe_hold, aclk, aresetn, out_valid && !out_ready,
                      out_valid && $stable(out_req))

endmodule

// ===== rtl/core/srfc_serializer.sv =====
// ---------------------------------------------------------------------------
// srfc_serializer
// Holds one finished frame and sends its thirteen bytes, one per cycle while m_tready is high.
// ---------------------------------------------------------------------------
`include "sensor_response_frame_crc16_unit_defines.svh"

module srfc_serializer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           slave_address,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  srfc_pkg::frame_req_t in_req,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);

    logic                 busy_reg;
    logic                 busy_next;
    logic [3:0]           idx_reg;
    logic [3:0]           idx_next;
    srfc_pkg::frame_req_t frame_reg;
    logic                 last_sent;

    assign m_tlast   = (idx_reg == srfc_pkg::IDX_CRC_LO);
    assign last_sent = busy_reg && m_tready && m_tlast;
    assign in_ready  = !busy_reg || last_sent;
    assign m_tvalid  = busy_reg;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (in_valid && in_ready) begin
            busy_next = 1'b1;
            idx_next  = srfc_pkg::IDX_ADDR;
        end else if (last_sent) begin
            busy_next = 1'b0;
            idx_next  = srfc_pkg::IDX_ADDR;
        end else if (busy_reg && m_tready) begin
            idx_next  = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= srfc_pkg::IDX_ADDR;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
        if (in_valid && in_ready) begin
            frame_reg <= in_req;
        end
    end

    always_comb begin
        case (idx_reg)
            srfc_pkg::IDX_ADDR:   m_tdata = slave_address;
            srfc_pkg::IDX_FUNC:   m_tdata = srfc_pkg::FUNC_CODE;
            srfc_pkg::IDX_COUNT:  m_tdata = srfc_pkg::BYTE_COUNT;
            srfc_pkg::IDX_IT_HI:  m_tdata = frame_reg.inner_temp[15:8];
            srfc_pkg::IDX_IT_LO:  m_tdata = frame_reg.inner_temp[7:0];
            srfc_pkg::IDX_ET_HI:  m_tdata = frame_reg.outer_temp[15:8];
            srfc_pkg::IDX_ET_LO:  m_tdata = frame_reg.outer_temp[7:0];
            srfc_pkg::IDX_CV_HI:  m_tdata = frame_reg.cell_voltage[15:8];
            srfc_pkg::IDX_CV_LO:  m_tdata = frame_reg.cell_voltage[7:0];
            srfc_pkg::IDX_PAD0:   m_tdata = srfc_pkg::PAD_BYTE;
            srfc_pkg::IDX_PAD1:   m_tdata = srfc_pkg::PAD_BYTE;
            srfc_pkg::IDX_CRC_HI: m_tdata = frame_reg.crc[15:8];
            srfc_pkg::IDX_CRC_LO: m_tdata = frame_reg.crc[7:0];
            default:              m_tdata = srfc_pkg::PAD_BYTE;
        endcase
    end

    `SRFC_ASSERT_NOW(a_take_only_at_end, aclk, aresetn, in_valid && in_ready && busy_reg,
                     m_tready && m_tlast)
    `SRFC_ASSERT_NEXT(a_idx_advance, aclk, aresetn, busy_reg && m_tready && !m_tlast,
                      busy_reg && idx_reg == $past(idx_reg) + 4'd1)
    `SRFC_ASSERT_NOW(a_idle_at_start, aclk, aresetn, !busy_reg,
                     idx_reg == srfc_pkg::IDX_ADDR)

endmodule

// ===== rtl/core/sensor_response_frame_crc16_unit.sv =====
// ---------------------------------------------------------------------------
// sensor_response_frame_crc16_unit
// Builds a 13-byte sensor response frame with a trailing CRC-16.
// ---------------------------------------------------------------------------
// Usage:
//   Present one reading set per request on the s_ channel: inner
//   temperature, outer temperature and cell voltage, 16 bits each.
//   For every request the m_ channel sends thirteen bytes in send order:
//   slave address, 0x04, 0x06, the three readings high byte first, two
//   zero bytes, then the CRC-16 (init 0xFFFF, reflected poly 0xA001) over
//   the first eleven bytes, high byte first. m_tlast marks the CRC low byte.
//   Path: a taken request enters the first CRC stage, passes three more
//   CRC stages, then the frame buffer, before its first byte appears.
//   The byte serializer sets the frame rate; it takes the next frame as
//   it sends the last byte of the current one. The CRC pipeline takes a
//   request every cycle unless stalled and buffers up to four
//   frames while the serializer drains.
//   Reset (aresetn low, synchronous) drops all requests in flight and sets
//   the slave address to 1. Write cfg_wdata with cfg_we only while idle.
//   When the receiver holds m_tready low, hold the current byte; the
//   pipeline fills and then drops s_tready, losing nothing.
// ---------------------------------------------------------------------------
module sensor_response_frame_crc16_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,       // slave_address
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,         // inner_temp, outer_temp, cell_voltage
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,         // frame_byte
    output logic        m_tlast
);

    logic [7:0]           slave_address_reg;
    srfc_pkg::frame_req_t in_req;
    srfc_pkg::frame_req_t crc_req;
    logic                 crc_valid;
    logic                 crc_ready;

    // Hold the slave address; reset value is 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg <= 8'd1;
        end else if (cfg_we) begin
            slave_address_reg <= cfg_wdata;
        end
    end

    // Unpack the request; the CRC field starts at CRC_INIT and the first stage overwrites it
    always_comb begin
        in_req.inner_temp   = s_tdata[15:0];
        in_req.outer_temp   = s_tdata[31:16];
        in_req.cell_voltage = s_tdata[47:32];
        in_req.crc          = srfc_pkg::CRC_INIT;
    end

    // Advance the readings through the CRC stages
    srfc_crc_pipe u_crc_pipe (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .slave_address (slave_address_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_req        (in_req),
        .out_valid     (crc_valid),
        .out_ready     (crc_ready),
        .out_req       (crc_req)
    );

    // Send the finished frame one byte per cycle while m_tready is high
    srfc_serializer u_serializer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .slave_address (slave_address_reg),
        .in_valid      (crc_valid),
        .in_ready      (crc_ready),
        .in_req        (crc_req),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

// ===== verif/tb_sensor_response_frame_crc16_unit.sv =====
// ---------------------------------------------------------------------------
// tb_sensor_response_frame_crc16_unit
// Streams reading sets into the frame unit and checks every response byte
// and its last marker against frames predicted here, with the CRC-16
// worked out bit by bit. Covers field extremes, slave address extremes,
// random traffic with stalls on both sides, a long receiver hold-off that
// fills the block, and a final stretch at full rate.
// ---------------------------------------------------------------------------
module tb_sensor_response_frame_crc16_unit;

    localparam int FRAME_BYTES   = 13;
    localparam int CRC_SPAN      = 11;
    localparam int SETTLE_CYCLES = 8;     // idle margin after the last due byte
    localparam int DRAIN_LIMIT   = 20000;
    localparam int MAX_REPORTS   = 10;

    // One expected byte of a response frame
    typedef struct {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = 48'h0;    // inner_temp, outer_temp, cell_voltage
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;              // frame_byte
    logic        m_tlast;

    // Bytes still owed by the block, oldest first
    frame_byte_t bytes_due[$];

    // Slave address as the block should hold it
    logic [7:0]  addr_model = 8'h01;

    int          mismatches    = 0;
    int          frames_sent   = 0;
    int          bytes_checked = 0;
    int          addr_settings = 1;

    // Receiver control: random stalls on or off, and a one-shot long hold-off
    bit          rx_stalls_on  = 1'b1;
    int unsigned hold_off_len  = 0;

    sensor_response_frame_crc16_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------

    // CRC-16 over the first eleven frame bytes, one bit at a time, LSB first
    function automatic logic [15:0] frame_crc(input logic [7:0] frame [FRAME_BYTES]);
        logic [15:0] crc;
        logic        feedback;
        crc = srfc_pkg::CRC_INIT;
        for (int k = 0; k < CRC_SPAN; k++) begin
            for (int b = 0; b < 8; b++) begin
                feedback = crc[0] ^ frame[k][b];
                crc      = crc >> 1;
                if (feedback) begin
                    crc = crc ^ srfc_pkg::CRC_POLY;
                end
            end
        end
        return crc;
    endfunction

    // Build the full response frame for one reading set and queue its bytes
    task automatic queue_response_frame(input logic [15:0] itemp,
                                        input logic [15:0] etemp,
                                        input logic [15:0] volts);
        logic [7:0]  frame [FRAME_BYTES];
        logic [15:0] crc;
        frame_byte_t fb;
        frame[0]  = addr_model;
        frame[1]  = srfc_pkg::FUNC_CODE;
        frame[2]  = srfc_pkg::BYTE_COUNT;
        frame[3]  = itemp[15:8];
        frame[4]  = itemp[7:0];
        frame[5]  = etemp[15:8];
        frame[6]  = etemp[7:0];
        frame[7]  = volts[15:8];
        frame[8]  = volts[7:0];
        frame[9]  = srfc_pkg::PAD_BYTE;
        frame[10] = srfc_pkg::PAD_BYTE;
        crc       = frame_crc(frame);
        frame[11] = crc[15:8];
        frame[12] = crc[7:0];
        for (int k = 0; k < FRAME_BYTES; k++) begin
            fb.value = frame[k];
            fb.last  = (k == FRAME_BYTES - 1);
            bytes_due.push_back(fb);
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    // -----------------------------------------------------------------------
    // Response checking: compare each accepted byte with the oldest one due
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin : check_response
        frame_byte_t due;
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (bytes_due.size() == 0) begin
                report_mismatch($sformatf("byte %02h last %b with no frame pending",
                                          m_tdata, m_tlast));
            end else begin
                due = bytes_due.pop_front();
                bytes_checked++;
                if (m_tdata !== due.value || m_tlast !== due.last) begin
                    report_mismatch($sformatf(
                        "frame_byte exp %02h got %02h, last_byte exp %b got %b",
                        due.value, m_tdata, due.last, m_tlast));
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: random ready bursts, plus a long hold-off counted here
    // -----------------------------------------------------------------------
    initial begin : drive_ready
        int unsigned n;
        forever begin
            if (hold_off_len > 0) begin
                // hold the output off so the block fills and stalls its input
                n            = hold_off_len;
                hold_off_len = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (rx_stalls_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sender side
    // -----------------------------------------------------------------------

    // Offer one request and hold it until taken. Valid stays high afterwards;
    // the caller lowers it, or replaces the data, in the same time step.
    task automatic send_reading(input logic [15:0] itemp,
                                input logic [15:0] etemp,
                                input logic [15:0] volts);
        s_tvalid <= 1'b1;
        s_tdata  <= {volts, etemp, itemp};
        do @(posedge aclk); while (s_tready !== 1'b1);
        queue_response_frame(itemp, etemp, volts);
        frames_sent++;
    endtask

    task automatic idle_sender(input int unsigned cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Drop valid, wait for every due byte, then let the pipeline settle
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (bytes_due.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the address register; only call with the block idle
    task automatic set_slave_address(input logic [7:0] addr);
        cfg_wdata <= addr;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        addr_model = addr;
        addr_settings++;
    endtask

    // Mostly full random readings, with a share of byte-boundary corners
    function automatic logic [15:0] pick_reading();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h00FF << ($urandom_range(0, 1) * 8);
            3:       return 16'h0001 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    // Random requests; gap_odds of 0 means no sender gaps at all
    task automatic send_random_readings(input int count, input int gap_odds);
        for (int i = 0; i < count; i++) begin
            if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
                idle_sender($urandom_range(1, 18));
            end
            send_reading(pick_reading(), pick_reading(), pick_reading());
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Reset address of 1, all-zero and all-one readings
    task automatic test_reset_address();
        send_reading(16'h0000, 16'h0000, 16'h0000);
        send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF);
        idle_sender(3);
        send_reading(16'h0000, 16'hFFFF, 16'h0000);
        wait_drained();
    endtask

    // High and low bytes must land apart: distinct patterns in every field
    task automatic test_field_extremes();
        send_reading(16'h1234, 16'hABCD, 16'h8001);
        send_reading(16'hFF00, 16'h00FF, 16'hFF00);
        send_reading(16'h00FF, 16'hFF00, 16'h00FF);
        send_reading(16'h8000, 16'h8000, 16'h8000);
        send_reading(16'h0001, 16'h0001, 16'h0001);
        send_reading(16'hAAAA, 16'h5555, 16'hAAAA);
        send_reading(16'h5555, 16'hAAAA, 16'h5555);
        send_reading(16'h7FFF, 16'hFFFE, 16'h0F0F);
        wait_drained();
    endtask

    // Address register at both ends of its range, then back to a middle value
    task automatic test_address_extremes();
        set_slave_address(8'h00);
        send_reading(16'h0000, 16'h0000, 16'h0000);
        send_reading(16'hC3A5, 16'h5A3C, 16'h1E2D);
        wait_drained();
        set_slave_address(8'hFF);
        send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_reading(16'h0102, 16'h0304, 16'h0506);
        wait_drained();
        set_slave_address(8'hA5);
        send_reading(16'h4321, 16'h8765, 16'hCBA9);
        wait_drained();
    endtask

    // Random readings under random stalls, with a new address per phase
    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++) begin
            set_slave_address(8'($urandom));
            // alternate heavy and light sender gaps so some runs are gapless
            send_random_readings(45, 3);
            send_random_readings(45, 12);
            wait_drained();
        end
    endtask

    // Hold the receiver off for a long stretch while requests keep coming
    task automatic test_backpressure_fill();
        set_slave_address(8'h5A);
        hold_off_len = 300;
        send_random_readings(40, 0);
        wait_drained();
    endtask

    // Last stretch: no idling on either side
    task automatic test_full_rate();
        rx_stalls_on = 1'b0;
        set_slave_address(8'h01);
        send_random_readings(80, 0);
        wait_drained();
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial begin : run_tests
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_reset_address();
        test_field_extremes();
        test_address_extremes();
        test_random_traffic();
        test_backpressure_fill();
        test_full_rate();

        // anything still due never arrived
        if (bytes_due.size() != 0) begin
            report_mismatch($sformatf("%0d bytes never sent", bytes_due.size()));
        end

        $display("covered %0d frames, %0d bytes checked, %0d address settings",
                 frames_sent, bytes_checked, addr_settings);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Generous bound: every byte waiting out the longest stall, several times over
    initial begin : watchdog
        #6000000;
        $display("timeout waiting on the frame unit");
        $display("status: fail");
        $finish;
    end

endmodule
